// ===== rtl/greedy_vertex_coloring_defines.svh =====
// Assertion macros shared by the greedy vertex coloring RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef GREEDY_VERTEX_COLORING_DEFINES_SVH
`define GREEDY_VERTEX_COLORING_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GVC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GVC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gvc_pkg.sv =====
// Types, constants and helper functions of the greedy vertex coloring block.
// No dependencies; imported by greedy_vertex_coloring, gvc_rsp_queue and the testbench.
`default_nettype none

package gvc_pkg;

   localparam int VERTICES   = 1024;
   localparam int MAX_DEGREE = 63;
   localparam int NUM_COLORS = 64;

   localparam int VID_W   = 10;
   localparam int COLOR_W = 7;
   localparam int VTX_AW  = $clog2(VERTICES);
   localparam int EXT_W   = ((VTX_AW > VID_W) ? VTX_AW : VID_W) + 1;

   localparam logic OP_NEIGHBOR = 1'b0;
   localparam logic OP_CLEAR    = 1'b1;

   typedef struct packed {
      logic             op;
      logic [VID_W-1:0] vertex_id;
      logic [VID_W-1:0] neighbor_id;
      logic             has_neighbor;
      logic             last_neighbor;
   } req_type;

   typedef struct packed {
      logic [VID_W-1:0]   colored_vertex;
      logic [COLOR_W-1:0] chosen_color;
      logic [COLOR_W-1:0] colors_used;
      logic               overflow;
   } rsp_type;

   typedef enum logic {
      ST_RUN,
      ST_CLEAR
   } state_type;

   // True when the id names an entry of the color store.
   function automatic logic id_in_range(input logic [VID_W-1:0] id);
      return EXT_W'(id) < EXT_W'(VERTICES);
   endfunction

   function automatic logic [VTX_AW-1:0] id_addr(input logic [VID_W-1:0] id);
      logic [EXT_W-1:0] ext;
      ext = EXT_W'(id);
      return ext[VTX_AW-1:0];
   endfunction

   // One-hot mask bit of a color; color 0 (uncolored) marks nothing.
   function automatic logic [NUM_COLORS-1:0] color_bit(input logic [COLOR_W-1:0] c);
      logic [NUM_COLORS-1:0] m;
      for (int k = 0; k < NUM_COLORS; k++) begin
         m[k] = (c == COLOR_W'(k + 1));
      end
      return m;
   endfunction

   // Smallest color whose mask bit is clear; 0 when all are taken.
   function automatic logic [COLOR_W-1:0] first_free(input logic [NUM_COLORS-1:0] mask);
      logic [COLOR_W-1:0] res;
      res = '0;
      for (int k = NUM_COLORS - 1; k >= 0; k--) begin
         if (!mask[k]) begin
            res = COLOR_W'(k + 1);
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/greedy_vertex_coloring.sv =====
// Top level of the first-fit greedy vertex coloring block.
// Depends on gvc_pkg, gvc_ram, gvc_rsp_queue and greedy_vertex_coloring_defines.svh.
`default_nettype none

`include "greedy_vertex_coloring_defines.svh"

// First-fit greedy vertex coloring. Send each vertex, in coloring order, as a
// run of neighbor requests with last_neighbor set on the final one (an isolated
// vertex sends one request with has_neighbor low). The block takes one request
// per cycle, back to back: the color store is a 1024 x 7 synchronous RAM, read
// at the neighbor id in the cycle a request is accepted, and the next cycle
// marks that color in the used-color mask, picks the first free color on the
// last request, writes it back and pushes the result, which reaches rsp_valid from
// the result queue register. A write in the same cycle as a read of the same
// vertex is forwarded, so a neighbor colored just before is seen. req_ready
// drops only when the two-entry result queue would fill, and during a clearing
// pass: after reset, and after every clear request has passed the mark/pick
// stage, the store is swept one entry per cycle over all VERTICES (1024)
// entries. chosen_color is 0 with overflow set when every color 1..64 is taken
// by neighbors; such a vertex is stored uncolored.
module greedy_vertex_coloring
   import gvc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   // request stage
   logic req_fire;

   // color store ports
   logic               wr_en;
   logic [VTX_AW-1:0]  wr_addr;
   logic [COLOR_W-1:0] wr_data;
   logic [VTX_AW-1:0]  rd_addr;
   logic [COLOR_W-1:0] rd_data;

   // mark/pick stage
   logic               s1_valid_ff, s1_valid_in;
   req_type            s1_req_ff;
   logic               s1_rd_ok_ff;
   logic               fwd_hit_ff;
   logic [COLOR_W-1:0] fwd_color_ff;

   logic [NUM_COLORS-1:0] mask_ff, mask_in;
   logic [COLOR_W-1:0]    max_ff, max_in;

   logic [COLOR_W-1:0]    nb_color;
   logic [NUM_COLORS-1:0] mask_now;
   logic                  is_clear;
   logic                  is_run;
   logic                  is_last;
   logic [COLOR_W-1:0]    pick;
   logic [COLOR_W-1:0]    max_new;
   rsp_type               result;

   // clearing sweep
   state_type         state_ff, state_in;
   logic [VTX_AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic              sweep_on;
   logic              sweep_done;

   // result queue
   logic       q_push;
   logic       rsp_pop;
   logic [1:0] q_level;
   logic [1:0] q_after;
   logic       q_room;

   assign req_fire = req_valid && req_ready;
   assign rsp_pop  = rsp_valid && rsp_ready;

   // ---------------------------------------------------------------------
   // Color store: read the neighbor on accept, write the chosen color (or a
   // zero during the sweep) from the mark/pick stage.
   // ---------------------------------------------------------------------
   assign rd_addr = id_addr(req_payload.neighbor_id);

   gvc_ram #(
      .WIDTH (COLOR_W),
      .DEPTH (VERTICES)
   ) u_color_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (sweep_on) begin
         wr_en   = 1'b1;
         wr_addr = sweep_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = is_last && id_in_range(s1_req_ff.vertex_id);
         wr_addr = id_addr(s1_req_ff.vertex_id);
         wr_data = pick;
      end
   end

   // ---------------------------------------------------------------------
   // Mark/pick stage. Take the forwarded color when the read collided with
   // the write of the previous vertex; otherwise the RAM data.
   // ---------------------------------------------------------------------
   assign nb_color = fwd_hit_ff ? fwd_color_ff : rd_data;
   assign mask_now = mask_ff | (s1_rd_ok_ff ? color_bit(nb_color) : '0);
   assign is_clear = s1_valid_ff && (s1_req_ff.op == OP_CLEAR);
   assign is_run   = s1_valid_ff && (s1_req_ff.op == OP_NEIGHBOR);
   assign is_last  = is_run && s1_req_ff.last_neighbor;
   assign pick     = first_free(mask_now);
   assign max_new  = (pick > max_ff) ? pick : max_ff;

   always_comb begin
      mask_in = mask_ff;
      max_in  = max_ff;
      priority if (is_clear) begin
         mask_in = '0;
         max_in  = '0;
      end else if (is_last) begin
         // drop the mask for the next vertex
         mask_in = '0;
         max_in  = max_new;
      end else if (is_run) begin
         mask_in = mask_now;
      end
   end

   always_comb begin
      result.colored_vertex = s1_req_ff.vertex_id;
      result.chosen_color   = pick;
      result.colors_used    = max_new;
      result.overflow       = (pick == '0);
   end

   assign s1_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         mask_ff     <= '0;
         max_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         mask_ff     <= mask_in;
         max_ff      <= max_in;
      end
      if (req_fire) begin
         s1_req_ff    <= req_payload;
         s1_rd_ok_ff  <= req_payload.has_neighbor && id_in_range(req_payload.neighbor_id);
         fwd_hit_ff   <= wr_en && (wr_addr == rd_addr);
         fwd_color_ff <= wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // Clearing sweep: entered at reset and when a clear request reaches the
   // mark/pick stage; walks every entry once.
   // ---------------------------------------------------------------------
   assign sweep_done = (sweep_cnt_ff == VTX_AW'(VERTICES - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (is_clear) begin
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (sweep_done) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      sweep_on     = 1'b0;
      sweep_cnt_in = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            sweep_on     = 1'b1;
            sweep_cnt_in = sweep_cnt_ff + VTX_AW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue. Accept a request only when the queue, after this cycle's
   // pop and push, still has room for what that request may produce.
   // ---------------------------------------------------------------------
   assign q_push  = is_last;
   assign q_after = q_level - {1'b0, rsp_pop} + {1'b0, q_push};
   assign q_room  = (q_after <= 2'd1);

   assign req_ready = (state_ff == ST_RUN) && !is_clear && q_room;

   gvc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (result),
      .pop        (rsp_pop),
      .head_valid (rsp_valid),
      .head_data  (rsp_payload),
      .level      (q_level)
   );

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `GVC_ASSERT_IMPLY(a_no_accept_in_sweep, clock, reset, state_ff == ST_CLEAR, !req_ready, "request accepted during clearing sweep")
   `GVC_ASSERT_IMPLY(a_queue_no_overrun, clock, reset, q_push, (q_level != 2'd2) || rsp_pop, "result pushed into a full queue")
   `GVC_ASSERT_NEXT(a_clear_blocks, clock, reset, req_fire && (req_payload.op == OP_CLEAR), !req_ready, "request accepted behind a clear")
   `GVC_ASSERT_IMPLY(a_color_bounds, clock, reset, rsp_valid && !rsp_payload.overflow, (rsp_payload.chosen_color != '0) && (rsp_payload.colors_used >= rsp_payload.chosen_color), "chosen color exceeds color count")

endmodule

`default_nettype wire

// ===== rtl/gvc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module gvc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/gvc_rsp_queue.sv =====
// Two-entry result queue that parts the coloring pipeline from the consumer.
// Depends on gvc_pkg for the result type.
`default_nettype none

module gvc_rsp_queue
   import gvc_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   input  wire logic    pop,
   output logic         head_valid,
   output rsp_type      head_data,
   output logic [1:0]   level
);

   rsp_type    q0_ff, q0_in;
   rsp_type    q1_ff, q1_in;
   logic [1:0] level_ff, level_in;

   always_comb begin
      q0_in    = q0_ff;
      q1_in    = q1_ff;
      level_in = level_ff - {1'b0, pop} + {1'b0, push};
      unique case ({push, pop})
         2'b10: begin
            if (level_ff == 2'd0) begin
               q0_in = push_data;
            end else begin
               q1_in = push_data;
            end
         end
         2'b01: begin
            q0_in = q1_ff;
         end
         2'b11: begin
            // shift the head out and append behind whatever remains
            if (level_ff == 2'd1) begin
               q0_in = push_data;
            end else begin
               q0_in = q1_ff;
               q1_in = push_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= 2'd0;
      end else begin
         level_ff <= level_in;
      end
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign head_valid = (level_ff != 2'd0);
   assign head_data  = q0_ff;
   assign level      = level_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the first-fit greedy vertex coloring block.
// Depends on gvc_pkg and greedy_vertex_coloring; drives requests, scores every coloring result.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gvc_pkg::*;

   // Size of the clique built at full rate; its members take colors 1..CLIQUE_N.
   localparam int CLIQUE_N = 16;

   // ---------------------------------------------------------------------
   // Clock, reset and the two channels of the block
   // ---------------------------------------------------------------------
   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   greedy_vertex_coloring u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the coloring state
   // ---------------------------------------------------------------------
   logic [COLOR_W-1:0]    model_colors [VERTICES];
   logic [NUM_COLORS-1:0] taken_mask;
   logic [COLOR_W-1:0]    peak_color;
   logic [COLOR_W-1:0]    highest_peak;

   req_type pending_reqs[$];        // requests not yet handed to the driver
   rsp_type expected_colorings[$];  // colorings predicted but not yet seen

   int send_idle_pct;
   int recv_idle_pct;
   int sent_count;
   int accepted_count;
   int results_checked;
   int overflows_seen;
   int clears_seen;
   int fail_count;
   logic req_accepted;

   // Hard bound on the run: far above the slowest legal run, clearing passes included.
   initial begin
      #4_800_000;
      $display("Simulation FAILED");
      $display("%0t: timeout, %0d colorings still outstanding", $time,
               expected_colorings.size());
      $finish;
   end

   // Forget every color, the mask and the running color count.
   function automatic void clear_coloring();
      for (int v = 0; v < VERTICES; v++) begin
         model_colors[v] = '0;
      end
      taken_mask = '0;
      peak_color = '0;
   endfunction

   // Advance the shadow state by one accepted request and queue any coloring it causes.
   function automatic void apply_request(input req_type r);
      rsp_type            res;
      logic [COLOR_W-1:0] pick;
      logic [COLOR_W-1:0] seen;
      if (r.op == OP_CLEAR) begin
         clear_coloring();
         clears_seen++;
         return;
      end
      // Mark the neighbor's color; uncolored or out-of-range neighbors mark nothing.
      if (r.has_neighbor && int'(r.neighbor_id) < VERTICES) begin
         seen = model_colors[r.neighbor_id];
         if (seen != 0 && seen <= NUM_COLORS) begin
            taken_mask[seen - 1] = 1'b1;
         end
      end
      if (!r.last_neighbor) begin
         return;
      end
      // Pick the lowest free color; zero means every color is taken.
      pick = '0;
      for (int k = 0; k < NUM_COLORS && pick == 0; k++) begin
         if (!taken_mask[k]) begin
            pick = COLOR_W'(k + 1);
         end
      end
      if (int'(r.vertex_id) < VERTICES) begin
         model_colors[r.vertex_id] = pick;
      end
      if (pick > peak_color) begin
         peak_color = pick;
      end
      if (peak_color > highest_peak) begin
         highest_peak = peak_color;
      end
      taken_mask = '0;
      res.colored_vertex = r.vertex_id;
      res.chosen_color   = pick;
      res.colors_used    = peak_color;
      res.overflow       = (pick == 0);
      if (res.overflow) begin
         overflows_seen++;
      end
      expected_colorings.push_back(res);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_coloring(input rsp_type want, input rsp_type got);
      check_field("colored_vertex", want.colored_vertex, got.colored_vertex);
      check_field("chosen_color", want.chosen_color, got.chosen_color);
      check_field("colors_used", want.colors_used, got.colors_used);
      check_field("overflow", want.overflow, got.overflow);
      results_checked++;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: change inputs on the falling edge only
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_accepted) begin
         // hold the request and its payload until the block takes it
      end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         req_valid   <= 1'b1;
         req_payload <= pending_reqs.pop_front();
         sent_count++;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: sample both handshakes on the rising edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && req_ready;
         // Predict at acceptance; a result always trails the requests that cause it.
         if (req_valid && req_ready) begin
            apply_request(req_payload);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_colorings.size() == 0) begin
               $display("%0t: unexpected coloring, expected none, actual %p", $time,
                        rsp_payload);
               fail_count++;
            end else begin
               check_coloring(expected_colorings.pop_front(), rsp_payload);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus builders (zero time, fill the pending queue)
   // ---------------------------------------------------------------------
   function automatic void push_req(input logic op, input int vid, input int nid,
                                    input int has_n, input int last);
      req_type r;
      r.op            = op;
      r.vertex_id     = VID_W'(vid);
      r.neighbor_id   = VID_W'(nid);
      r.has_neighbor  = 1'(has_n);
      r.last_neighbor = 1'(last);
      pending_reqs.push_back(r);
   endfunction

   // Short directed opener: id extremes, forwarding, self-loops, recoloring, clears.
   function automatic void queue_directed_checks();
      push_req(OP_NEIGHBOR, 0, 0, 0, 1);        // isolated vertex gets color 1
      push_req(OP_NEIGHBOR, 1023, 0, 1, 1);     // neighbor colored one request earlier
      push_req(OP_NEIGHBOR, 1, 1023, 1, 0);
      push_req(OP_NEIGHBOR, 1, 0, 1, 0);
      push_req(OP_NEIGHBOR, 1, 512, 1, 1);      // uncolored neighbor marks nothing
      push_req(OP_NEIGHBOR, 1023, 1023, 0, 0);  // ignored: no neighbor, not last
      push_req(OP_NEIGHBOR, 2, 2, 1, 1);        // self-loop while still uncolored
      push_req(OP_NEIGHBOR, 2, 2, 1, 0);        // recolor: self reads its old color
      push_req(OP_NEIGHBOR, 2, 1, 1, 1);
      push_req(OP_NEIGHBOR, 3, 1023, 1, 0);
      push_req(OP_NEIGHBOR, 3, 0, 0, 1);        // run closed by a neighborless item
      push_req(OP_CLEAR, 1023, 1023, 1, 1);     // clear with every other bit high
      push_req(OP_NEIGHBOR, 1023, 0, 1, 1);     // old colors are gone
      push_req(OP_NEIGHBOR, 1022, 1023, 1, 1);
      push_req(OP_CLEAR, 0, 0, 0, 0);           // clear with every other bit low
   endfunction

   // Build a clique (colors 1..CLIQUE_N), then color vertices that touch all of it.
   function automatic void queue_clique();
      int order [CLIQUE_N];
      int j;
      int tmp;
      push_req(OP_CLEAR, 0, 0, 0, 0);
      push_req(OP_NEIGHBOR, 0, 0, 0, 1);
      for (int v = 1; v < CLIQUE_N; v++) begin
         for (int n = 0; n < v; n++) begin
            push_req(OP_NEIGHBOR, v, n, 1, int'(n == v - 1));
         end
      end
      for (int k = 0; k < CLIQUE_N; k++) begin
         order[k] = k;
      end
      for (int k = CLIQUE_N - 1; k > 0; k--) begin
         j        = $urandom_range(0, k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      // Neighbors in shuffled order; the vertex takes the first color above the clique.
      for (int k = 0; k < CLIQUE_N; k++) begin
         push_req(OP_NEIGHBOR, 200, order[k], 1, int'(k == CLIQUE_N - 1));
      end
      // Recolor the last clique member against the whole clique, itself included.
      for (int n = 0; n < CLIQUE_N; n++) begin
         push_req(OP_NEIGHBOR, CLIQUE_N - 1, n, 1, int'(n == CLIQUE_N - 1));
      end
   endfunction

   // Mostly well-formed vertex runs with random content, plus noise and clears.
   function automatic void queue_random_traffic(input int target);
      int counted;
      int pick;
      int pool_hi;
      int vid;
      int deg;
      int nid;
      bit tail_free;
      counted = 0;
      while (counted < target) begin
         pick    = $urandom_range(0, 99);
         pool_hi = ($urandom_range(0, 3) == 0) ? VERTICES - 1 : 63;
         if (pick < 3) begin
            push_req(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1), $urandom_range(0, 1));
            counted++;
         end else if (pick < 9) begin
            push_req(OP_NEIGHBOR, $urandom_range(0, 1023), $urandom_range(0, 1023), 0, 0);
         end else begin
            vid = $urandom_range(0, pool_hi);
            if (pick < 20) begin
               deg = 0;
            end else if (pick < 30) begin
               deg = $urandom_range(7, 24);
            end else begin
               deg = $urandom_range(1, 6);
            end
            tail_free = (deg == 0) || ($urandom_range(0, 6) == 0);
            for (int i = 0; i < deg; i++) begin
               if ($urandom_range(0, 19) == 0) begin
                  push_req(OP_NEIGHBOR, vid, $urandom_range(0, 1023), 0, 0);
               end
               nid = ($urandom_range(0, 9) == 0) ? vid : $urandom_range(0, pool_hi);
               push_req(OP_NEIGHBOR, vid, nid, 1, int'(!tail_free && i == deg - 1));
               counted++;
            end
            if (tail_free) begin
               push_req(OP_NEIGHBOR, vid, $urandom_range(0, 1023), 0, 1);
               counted++;
            end
         end
      end
   endfunction

   // Hold until every queued request is taken and every predicted coloring has arrived.
   task automatic wait_for_idle();
      do begin
         @(posedge clock);
         #1;
      end while (pending_reqs.size() != 0 || sent_count != accepted_count ||
                 expected_colorings.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      clear_coloring();
      highest_peak    = '0;
      sent_count      = 0;
      accepted_count  = 0;
      results_checked = 0;
      overflows_seen  = 0;
      clears_seen     = 0;
      fail_count      = 0;
      send_idle_pct   = 13;
      recv_idle_pct   = 85;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: light sender gaps, heavy receiver back-pressure.
      queue_directed_checks();
      queue_random_traffic(150);
      wait_for_idle();

      // Phase two: swap the idling; the sender has drained fully before this point.
      send_idle_pct = 85;
      recv_idle_pct = 13;
      queue_random_traffic(150);
      wait_for_idle();

      // Phase three: full rate, clique build, then more random runs.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_clique();
      queue_random_traffic(150);
      wait_for_idle();

      // Let a late or spurious result show up before closing.
      repeat (20) @(posedge clock);
      #1;
      $display("Run covered %0d requests and %0d colorings (%0d overflows, %0d clears).",
               accepted_count, results_checked, overflows_seen, clears_seen);
      $display("Highest color count reached: %0d; mismatches: %0d.", highest_peak,
               fail_count);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/gvc_pkg.sv
rtl/gvc_ram.sv
rtl/gvc_rsp_queue.sv
rtl/greedy_vertex_coloring.sv
tb/sv/tb_top.sv
